[rtl/core/mps_pkg.sv]
// Shared types and constants for the motion platform supervisor.
`default_nettype none

package mps_pkg;

    localparam int CNT_W = 24;
    localparam int FLAG_W = 5;
    localparam int Q_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] RETRY_RESET = 24'd10;

    localparam int F_CONN = 0;
    localparam int F_HEALTH = 1;
    localparam int F_HOMED = 2;
    localparam int F_HALT = 3;
    localparam int F_MOTION = 4;

    typedef enum logic [0:0] {
        CFG_CONNECT_RETRY = 1'd0,
        CFG_HEALTH_RETRY  = 1'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_INIT    = 4'd0,
        S_CONNECT = 4'd1,
        S_HEALTH  = 4'd2,
        S_DISC    = 4'd3,
        S_ERR     = 4'd4,
        S_UNINIT  = 4'd5,
        S_STHOME  = 4'd6,
        S_WTHOME  = 4'd7,
        S_STOPPED = 4'd8,
        S_HALTED  = 4'd9,
        S_STMOVE  = 4'd10,
        S_MOVING  = 4'd11
    } t_sup;

    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_INIT = 2'd1,
        REQ_MOVE = 2'd2,
        REQ_HALT = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        MS_NONE    = 3'd0,
        MS_UNINIT  = 3'd1,
        MS_INITING = 3'd2,
        MS_INITED  = 3'd3,
        MS_STOPPED = 3'd4,
        MS_MOVING  = 3'd5
    } t_motion;

    typedef struct packed {
        logic [FLAG_W-1:0] flag_set;
        logic [FLAG_W-1:0] flag_clear;
        logic              state_request_valid;
        t_req              state_request;
        logic              motion_request_valid;
        logic [Q_W-1:0]    distance;
        logic [Q_W-1:0]    velocity;
        logic [1:0]        direction_request;
    } t_item;

    typedef struct packed {
        t_sup              sup;
        logic [FLAG_W-1:0] flags;
        t_motion           motion;
        t_req              req;
        logic [Q_W-1:0]    pdist;
        logic [Q_W-1:0]    vel;
        logic [1:0]        dir;
        logic [CNT_W-1:0]  cnt;
    } t_state;

    typedef struct packed {
        t_sup           sup;
        t_motion        motion;
        logic           home;
        logic           stop;
        logic           move;
        logic [Q_W-1:0] mdist;
        logic [Q_W-1:0] mvel;
        logic           dir;
        logic [1:0]     dcode;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/mps_step.sv]
// Combinational supervisor step: flag update, request latching and one state transition.
`default_nettype none

module mps_step (
    input  wire mps_pkg::t_state          i_state,
    input  wire mps_pkg::t_item           i_item,
    input  wire [mps_pkg::CNT_W-1:0]      i_connect_retry,
    input  wire [mps_pkg::CNT_W-1:0]      i_health_retry,
    output mps_pkg::t_state               o_state,
    output mps_pkg::t_result              o_result
);

    logic [mps_pkg::FLAG_W-1:0] flags;
    mps_pkg::t_req              req;
    logic [mps_pkg::Q_W-1:0]    pdist;
    logic [mps_pkg::Q_W-1:0]    vel;
    logic [1:0]                 dir;
    logic                       lost;
    mps_pkg::t_sup              lost_tgt;
    logic [mps_pkg::CNT_W-1:0]  cnt_inc;
    logic                       mv_ok;
    mps_pkg::t_sup              sup_next;

    always_comb begin
        flags = (i_state.flags | i_item.flag_set) & ~i_item.flag_clear;
        req = i_item.state_request_valid ? i_item.state_request : i_state.req;
        pdist = i_item.motion_request_valid ? i_item.distance : i_state.pdist;
        vel = i_item.motion_request_valid ? i_item.velocity : i_state.vel;
        dir = (i_item.direction_request != 2'd0) ? i_item.direction_request : i_state.dir;
        lost = !(flags[mps_pkg::F_CONN] && flags[mps_pkg::F_HEALTH]);
        lost_tgt = flags[mps_pkg::F_CONN] ? mps_pkg::S_HEALTH : mps_pkg::S_CONNECT;
        cnt_inc = (i_state.cnt == mps_pkg::CNT_MAX) ? i_state.cnt
                                                    : i_state.cnt + 1'b1;
        mv_ok = (pdist != '0) && !vel[mps_pkg::Q_W-1] && (vel != '0);
    end

    always_comb begin
        sup_next = i_state.sup;
        unique case (i_state.sup)
            mps_pkg::S_CONNECT: begin
                sup_next = flags[mps_pkg::F_CONN] ? mps_pkg::S_HEALTH : mps_pkg::S_DISC;
            end
            mps_pkg::S_HEALTH: begin
                if (!lost) begin
                    sup_next = mps_pkg::S_UNINIT;
                end else if (!flags[mps_pkg::F_CONN]) begin
                    sup_next = mps_pkg::S_CONNECT;
                end else begin
                    sup_next = mps_pkg::S_ERR;
                end
            end
            mps_pkg::S_DISC: begin
                if (cnt_inc > i_connect_retry) begin
                    sup_next = mps_pkg::S_CONNECT;
                end
            end
            mps_pkg::S_ERR: begin
                if (cnt_inc > i_health_retry) begin
                    sup_next = mps_pkg::S_HEALTH;
                end
            end
            mps_pkg::S_UNINIT: begin
                if (lost) begin
                    sup_next = lost_tgt;
                end else if (req == mps_pkg::REQ_INIT) begin
                    sup_next = mps_pkg::S_STHOME;
                end
            end
            mps_pkg::S_STHOME: begin
                if (lost) begin
                    sup_next = lost_tgt;
                end else if (req == mps_pkg::REQ_INIT
                             && i_state.motion == mps_pkg::MS_UNINIT
                             && !flags[mps_pkg::F_HOMED]) begin
                    sup_next = mps_pkg::S_WTHOME;
                end
            end
            mps_pkg::S_WTHOME: begin
                if (lost) begin
                    sup_next = lost_tgt;
                end else if (req == mps_pkg::REQ_HALT) begin
                    sup_next = mps_pkg::S_HALTED;
                end else if (flags[mps_pkg::F_HOMED]) begin
                    sup_next = mps_pkg::S_STOPPED;
                end
            end
            mps_pkg::S_STOPPED: begin
                if (lost) begin
                    sup_next = lost_tgt;
                end else if (req == mps_pkg::REQ_HALT) begin
                    sup_next = mps_pkg::S_HALTED;
                end else if (req == mps_pkg::REQ_MOVE) begin
                    sup_next = mps_pkg::S_STMOVE;
                end
            end
            mps_pkg::S_HALTED: begin
                if (flags[mps_pkg::F_HALT]) begin
                    sup_next = mps_pkg::S_STOPPED;
                end
            end
            mps_pkg::S_STMOVE: begin
                if (lost) begin
                    sup_next = lost_tgt;
                end else if (mv_ok) begin
                    sup_next = mps_pkg::S_MOVING;
                end
            end
            mps_pkg::S_MOVING: begin
                if (lost) begin
                    sup_next = lost_tgt;
                end else if (req == mps_pkg::REQ_HALT) begin
                    sup_next = mps_pkg::S_HALTED;
                end else if (!flags[mps_pkg::F_MOTION]) begin
                    sup_next = mps_pkg::S_STOPPED;
                end
            end
            default: begin
                sup_next = mps_pkg::S_CONNECT;
            end
        endcase
    end

    always_comb begin
        o_state.sup = sup_next;
        o_state.flags = flags;
        o_state.motion = i_state.motion;
        o_state.req = req;
        o_state.pdist = pdist;
        o_state.vel = vel;
        o_state.dir = dir;
        o_state.cnt = i_state.cnt;
        o_result.home = 1'b0;
        o_result.stop = 1'b0;
        o_result.move = 1'b0;
        o_result.mdist = '0;
        o_result.mvel = '0;
        o_result.dir = 1'b0;
        o_result.dcode = 2'd0;
        unique case (i_state.sup)
            mps_pkg::S_CONNECT: begin
                if (!flags[mps_pkg::F_CONN]) begin
                    o_state.cnt = '0;
                end
            end
            mps_pkg::S_HEALTH: begin
                if (!lost) begin
                    o_state.req = mps_pkg::REQ_NONE;
                end else if (flags[mps_pkg::F_CONN]) begin
                    o_state.cnt = '0;
                end
            end
            mps_pkg::S_DISC, mps_pkg::S_ERR: begin
                o_state.cnt = cnt_inc;
            end
            mps_pkg::S_UNINIT: begin
                if (!lost) begin
                    o_state.motion = mps_pkg::MS_UNINIT;
                end
            end
            mps_pkg::S_STHOME: begin
                if (!lost && req == mps_pkg::REQ_INIT
                    && i_state.motion == mps_pkg::MS_UNINIT
                    && !flags[mps_pkg::F_HOMED]) begin
                    o_result.home = 1'b1;
                    o_state.req = mps_pkg::REQ_NONE;
                end
            end
            mps_pkg::S_WTHOME: begin
                if (!lost) begin
                    o_state.motion = mps_pkg::MS_INITING;
                    if (req == mps_pkg::REQ_HALT) begin
                        o_state.req = mps_pkg::REQ_NONE;
                    end else if (flags[mps_pkg::F_HOMED]) begin
                        o_state.req = mps_pkg::REQ_NONE;
                        o_state.pdist = '0;
                        o_state.vel = '0;
                        o_state.dir = 2'd0;
                        o_state.motion = mps_pkg::MS_INITED;
                    end
                end
            end
            mps_pkg::S_STOPPED: begin
                if (!lost) begin
                    o_state.motion = mps_pkg::MS_STOPPED;
                end
            end
            mps_pkg::S_HALTED: begin
                o_result.stop = 1'b1;
                if (flags[mps_pkg::F_HALT]) begin
                    o_state.req = mps_pkg::REQ_NONE;
                    o_state.pdist = '0;
                    o_state.vel = '0;
                end
            end
            mps_pkg::S_STMOVE: begin
                if (!lost) begin
                    if (dir != 2'd0) begin
                        o_result.dir = 1'b1;
                        o_result.dcode = dir;
                        o_state.dir = 2'd0;
                    end
                    if (mv_ok) begin
                        o_state.req = mps_pkg::REQ_NONE;
                        o_result.move = 1'b1;
                        o_result.mdist = pdist;
                        o_result.mvel = vel;
                    end
                end
            end
            mps_pkg::S_MOVING: begin
                if (!lost && req != mps_pkg::REQ_HALT) begin
                    if (flags[mps_pkg::F_MOTION]) begin
                        o_state.motion = mps_pkg::MS_MOVING;
                    end else begin
                        o_state.req = mps_pkg::REQ_NONE;
                        o_state.pdist = '0;
                        o_state.vel = '0;
                    end
                end
            end
            default: begin
                o_state.cnt = i_state.cnt;
            end
        endcase
        o_result.sup = sup_next;
        o_result.motion = o_state.motion;
    end

endmodule

`default_nettype wire

[rtl/core/motion_platform_supervisor_fsm.sv]
// Top level of the motion platform supervisor: input register, state, step logic and result register.
`default_nettype none

// Each input beat is one controller tick and yields exactly one result beat. A tick is taken
// into an input register, passes through the supervisor step logic, and its result lands
// in an output register; the supervisor state is updated in the same cycle as the result.
// The block sustains one tick per clock while the output side is not stalled. A result beat
// is held in the output register until the output side takes it; a stalled output register
// holds back the input register. Retry waits are counted in ticks, not clock cycles.
// Configuration writes are taken at any time and should be made while no tick is in flight.
module motion_platform_supervisor_fsm (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [4:0]  i_flag_set,
    input  wire  [4:0]  i_flag_clear,
    input  wire         i_state_request_valid,
    input  wire  [1:0]  i_state_request,
    input  wire         i_motion_request_valid,
    input  wire  signed [31:0] i_distance,
    input  wire  signed [31:0] i_velocity,
    input  wire  [1:0]  i_direction_request,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [3:0]  o_supervisor_state,
    output logic [2:0]  o_motion_state,
    output logic        o_issue_home,
    output logic        o_issue_stop,
    output logic        o_issue_move,
    output logic signed [31:0] o_move_distance,
    output logic signed [31:0] o_move_velocity,
    output logic        o_issue_direction,
    output logic [1:0]  o_direction_code
);

    logic [mps_pkg::CNT_W-1:0] r_connect_retry;
    logic [mps_pkg::CNT_W-1:0] r_health_retry;
    mps_pkg::t_item            r_item;
    logic                      r_item_valid;
    mps_pkg::t_state           r_state;
    mps_pkg::t_result          r_res;
    logic                      r_res_valid;
    mps_pkg::t_state           n_state;
    mps_pkg::t_result          n_res;
    logic                      advance;

    assign o_cfg_ready = 1'b1;
    assign advance = r_item_valid && (!r_res_valid || i_out_ready);
    assign o_in_ready = !r_item_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connect_retry <= mps_pkg::RETRY_RESET;
            r_health_retry <= mps_pkg::RETRY_RESET;
        end else if (i_cfg_valid) begin
            unique case (mps_pkg::t_cfg_idx'(i_cfg_index))
                mps_pkg::CFG_CONNECT_RETRY: r_connect_retry <= i_cfg_data;
                mps_pkg::CFG_HEALTH_RETRY:  r_health_retry <= i_cfg_data;
                default:                    r_connect_retry <= r_connect_retry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.flag_set <= i_flag_set;
            r_item.flag_clear <= i_flag_clear;
            r_item.state_request_valid <= i_state_request_valid;
            r_item.state_request <= mps_pkg::t_req'(i_state_request);
            r_item.motion_request_valid <= i_motion_request_valid;
            r_item.distance <= i_distance;
            r_item.velocity <= i_velocity;
            r_item.direction_request <= i_direction_request;
        end
    end

    mps_step u_step (
        .i_state         (r_state),
        .i_item          (r_item),
        .i_connect_retry (r_connect_retry),
        .i_health_retry  (r_health_retry),
        .o_state         (n_state),
        .o_result        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.sup <= mps_pkg::S_INIT;
            r_state.flags <= '0;
            r_state.motion <= mps_pkg::MS_NONE;
            r_state.req <= mps_pkg::REQ_NONE;
            r_state.pdist <= '0;
            r_state.vel <= '0;
            r_state.dir <= 2'd0;
            r_state.cnt <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_res_valid;
    assign o_supervisor_state = r_res.sup;
    assign o_motion_state = r_res.motion;
    assign o_issue_home = r_res.home;
    assign o_issue_stop = r_res.stop;
    assign o_issue_move = r_res.move;
    assign o_move_distance = r_res.mdist;
    assign o_move_velocity = r_res.mvel;
    assign o_issue_direction = r_res.dir;
    assign o_direction_code = r_res.dcode;

endmodule

`default_nettype wire
